// ----- rtl/core/rdt_pkg.sv -----
package rdt_pkg;

    localparam int COORD_BITS = 24;
    localparam int THR_BITS   = 52;
    localparam int SQ_BITS    = 2 * COORD_BITS;
    localparam int SUM_BITS   = SQ_BITS + 2;
    localparam int CMP_BITS   = (SUM_BITS > THR_BITS) ? SUM_BITS : THR_BITS;

    // x, y, z at indexes 0, 1, 2
    typedef logic [2:0][COORD_BITS-1:0] t_point;
    typedef logic [2:0][SQ_BITS-1:0]    t_sq3;
    typedef logic [1:0]                 t_count;

    localparam t_count CNT_NONE = 2'd0;
    localparam t_count CNT_ONE  = 2'd1;
    localparam t_count CNT_SAT  = 2'd3;

    typedef struct packed {
        t_point p;
        logic   closed;
        logic   last;
        t_sq3   sq_anc;
        t_sq3   sq_new;
    } t_stage_a;

    typedef struct packed {
        t_point p;
        logic   run_end;
        logic   line_done;
    } t_result;

endpackage

// ----- rtl/core/rdt_front.sv -----
module rdt_front
    import rdt_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_BITS-1:0] i_px,
    input  logic signed [COORD_BITS-1:0] i_py,
    input  logic signed [COORD_BITS-1:0] i_pz,
    input  logic                         i_ring_closed,
    input  logic                         i_final_vertex,
    input  logic                         i_take,
    input  t_point                       i_anchor,
    input  t_point                       i_b_point,
    output logic                         o_a_valid,
    output t_stage_a                     o_a
);

    logic   r_a_valid;
    t_point r_p;
    logic   r_closed;
    logic   r_last;

    function automatic t_sq3 sq_axes(input t_point a, input t_point b);
        t_sq3                   sq;
        logic signed [COORD_BITS:0] d;
        logic [COORD_BITS-1:0]  m;
        for (int i = 0; i < 3; i++) begin
            d     = {a[i][COORD_BITS-1], a[i]} - {b[i][COORD_BITS-1], b[i]};
            m     = d[COORD_BITS] ? COORD_BITS'(-d) : d[COORD_BITS-1:0];
            sq[i] = SQ_BITS'(m) * SQ_BITS'(m);
        end
        return sq;
    endfunction

    assign o_stall = r_a_valid & ~i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (!o_stall) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_p      <= {i_pz, i_py, i_px};
            r_closed <= i_ring_closed;
            r_last   <= i_final_vertex;
        end
    end

    // distance to the current anchor and to the vertex now in the decide stage,
    // which becomes the anchor if it is kept
    always_comb begin
        o_a_valid     = r_a_valid;
        o_a.p         = r_p;
        o_a.closed    = r_closed;
        o_a.last      = r_last;
        o_a.sq_anc    = sq_axes(r_p, i_anchor);
        o_a.sq_new    = sq_axes(r_p, i_b_point);
    end

endmodule

// ----- rtl/core/rdt_keep.sv -----
module rdt_keep
    import rdt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [THR_BITS-1:0] i_cfg_wdata,
    input  logic                i_a_valid,
    input  t_stage_a            i_a,
    output logic                o_a_take,
    output t_point              o_b_point,
    output t_point              o_anchor,
    output logic                o_push,
    output t_result             o_res,
    input  logic                i_out_free
);

    logic [THR_BITS-1:0] r_thr;
    logic                r_b_valid;
    t_point              r_p;
    logic                r_closed;
    logic                r_last;
    t_sq3                r_sq_anc;
    t_sq3                r_sq_new;
    logic                r_sel_new;
    logic                r_phase;
    t_point              r_anchor;
    t_point              r_prev;
    t_count              r_cnt;

    t_count              n_cnt;
    t_sq3                sq;
    logic [SUM_BITS-1:0] sum;
    logic                far;
    logic                first;
    logic                two;
    logic                emit_cur;
    logic                wr_anchor;
    logic                fire;

    always_comb begin
        sq        = r_sel_new ? r_sq_new : r_sq_anc;
        sum       = SUM_BITS'(sq[0]) + SUM_BITS'(sq[1]) + SUM_BITS'(sq[2]);
        far       = CMP_BITS'(sum) > CMP_BITS'(r_thr);
        first     = (r_cnt == CNT_NONE);
        two       = ~first & r_last & r_closed & (r_cnt != CNT_SAT) & ~r_phase;
        emit_cur  = first | r_last | far;
        wr_anchor = ~r_last & (first | far);
        fire      = r_b_valid & (~emit_cur | (i_out_free & ~two));
        o_a_take  = ~r_b_valid | fire;
        o_push    = r_b_valid & (two | emit_cur);
        if (two) begin
            o_res.p         = r_prev;
            o_res.run_end   = 1'b0;
            o_res.line_done = 1'b0;
        end else begin
            o_res.p         = r_p;
            o_res.run_end   = 1'b1;
            o_res.line_done = r_last;
        end
        o_b_point = r_p;
        o_anchor  = r_anchor;
        if (r_last) begin
            n_cnt = CNT_NONE;
        end else if (first) begin
            n_cnt = CNT_ONE;
        end else if (far && r_cnt != CNT_SAT) begin
            n_cnt = r_cnt + 2'd1;
        end else begin
            n_cnt = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= '0;
            r_b_valid <= 1'b0;
            r_sel_new <= 1'b0;
            r_phase   <= 1'b0;
            r_cnt     <= CNT_NONE;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (o_a_take) begin
                r_b_valid <= i_a_valid;
                r_sel_new <= fire & wr_anchor;
            end
            if (fire) begin
                r_phase <= 1'b0;
                r_cnt   <= n_cnt;
            end else if (two && i_out_free && r_b_valid) begin
                r_phase <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_a_take && i_a_valid) begin
            r_p      <= i_a.p;
            r_closed <= i_a.closed;
            r_last   <= i_a.last;
            r_sq_anc <= i_a.sq_anc;
            r_sq_new <= i_a.sq_new;
        end
        if (fire && !r_last) begin
            r_prev <= r_p;
            if (wr_anchor) begin
                r_anchor <= r_p;
            end
        end
    end

    a_phase_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> r_b_valid && r_last && r_closed)
        else $error("second result pending without a closed final vertex");

    a_line_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_last |=> r_cnt == CNT_NONE)
        else $error("kept count not cleared at end of line");

    a_sel_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && r_sel_new |-> r_cnt != CNT_NONE)
        else $error("new anchor selected at start of line");

    a_done_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_res.line_done |-> o_res.run_end)
        else $error("line end without request end");

endmodule

// ----- rtl/core/rdt_outreg.sv -----
module rdt_outreg
    import rdt_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  t_result                      i_res,
    output logic                         o_free,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [COORD_BITS-1:0] o_kx,
    output logic signed [COORD_BITS-1:0] o_ky,
    output logic signed [COORD_BITS-1:0] o_kz,
    output logic                         o_run_end,
    output logic                         o_line_done
);

    logic    r_valid;
    t_result r_res;

    assign o_free = ~r_valid | ~i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_push) begin
            r_res <= i_res;
        end
    end

    assign o_valid     = r_valid;
    assign o_kx        = r_res.p[0];
    assign o_ky        = r_res.p[1];
    assign o_kz        = r_res.p[2];
    assign o_run_end   = r_res.run_end;
    assign o_line_done = r_res.line_done;

endmodule

// ----- rtl/core/polyline_radial_distance_thinning.sv -----
// Radial-distance polyline thinning.
// Input channel: i_valid / o_stall carry one vertex per request (i_px, i_py,
// i_pz, i_ring_closed, i_final_vertex). Output channel: o_valid / i_stall
// carry one kept vertex per request (o_kx, o_ky, o_kz, o_run_end,
// o_line_done). A request moves at a rising edge with valid high, stall low.
// i_cfg_we / i_cfg_wdata write the squared spacing threshold; write it only
// while the block is idle.
// Pipeline: input register, decide stage, output register. Throughput is one
// vertex per cycle while the output does not stall. The final vertex of a
// closed ring with one or two kept vertices before it gives two results (the
// vertex before it, then itself) and holds the decide stage while it gives
// the extra result. The anchor compare is the loop that sets this rate.
// Reset (synchronous, active low) empties all stages, clears the threshold to
// zero and starts a new line. A stall on the output holds the output
// register; back-pressure reaches o_stall in the same cycle once the input
// stage is full and the decide stage holds a vertex that is to be output.
module polyline_radial_distance_thinning
    import rdt_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [THR_BITS-1:0]          i_cfg_wdata,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_BITS-1:0] i_px,
    input  logic signed [COORD_BITS-1:0] i_py,
    input  logic signed [COORD_BITS-1:0] i_pz,
    input  logic                         i_ring_closed,
    input  logic                         i_final_vertex,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [COORD_BITS-1:0] o_kx,
    output logic signed [COORD_BITS-1:0] o_ky,
    output logic signed [COORD_BITS-1:0] o_kz,
    output logic                         o_run_end,
    output logic                         o_line_done
);

    logic     a_valid;
    t_stage_a a_data;
    logic     a_take;
    t_point   b_point;
    t_point   anchor;
    logic     push;
    t_result  res;
    logic     out_free;

    rdt_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_px           (i_px),
        .i_py           (i_py),
        .i_pz           (i_pz),
        .i_ring_closed  (i_ring_closed),
        .i_final_vertex (i_final_vertex),
        .i_take         (a_take),
        .i_anchor       (anchor),
        .i_b_point      (b_point),
        .o_a_valid      (a_valid),
        .o_a            (a_data)
    );

    rdt_keep u_keep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_a_valid   (a_valid),
        .i_a         (a_data),
        .o_a_take    (a_take),
        .o_b_point   (b_point),
        .o_anchor    (anchor),
        .o_push      (push),
        .o_res       (res),
        .i_out_free  (out_free)
    );

    rdt_outreg u_outreg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_res       (res),
        .o_free      (out_free),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_kx        (o_kx),
        .o_ky        (o_ky),
        .o_kz        (o_kz),
        .o_run_end   (o_run_end),
        .o_line_done (o_line_done)
    );

endmodule
